// ----- rtl/core/vtr_pkg.sv -----
`default_nettype none

package vtr_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int ANGLE_WIDTH  = 14;
    localparam int FULL_TURN    = 5760;
    localparam int HALF_TURN    = 2880;
    localparam int QUARTER_TURN = 1440;
    localparam int TURN_WIDTH   = 15;
    localparam int QSINE_WIDTH  = 11;

    // Q4.60 working format of the sine series
    localparam int Q_WIDTH   = 64;
    localparam int Q_FRAC    = 60;
    localparam int DIV_WIDTH = 12;
    localparam int TERMS_MAX = 24;
    localparam logic [Q_WIDTH-1:0] PI_Q60 = 64'h3243F6A8885A308D;

    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_OPERATION = 2'd0,
        CFG_OFFSET    = 2'd1,
        CFG_ANGLE     = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        OP_MOVE_X = 3'd0,
        OP_MOVE_Y = 3'd1,
        OP_MOVE_Z = 3'd2,
        OP_ROT_X  = 3'd3,
        OP_ROT_Y  = 3'd4,
        OP_ROT_Z  = 3'd5
    } t_op;

endpackage

`default_nettype wire

// ----- rtl/core/vertex_translate_rotate.sv -----
`default_nettype none

// Channel   Direction  Handshake                    Payload
// cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
// vertex    in         i_valid / o_ready            i_coord_x/y/z, i_vertex_last
// result    out        o_valid / i_ready            o_out_x/y/z, o_out_last
//
// One vertex word per clock while no coefficient update runs and results are taken;
// each word is held in the input register, then the result register. Output stalls reach
// o_ready once both registers are full. Writing the angle runs the sine sequencer, twice per write:
//   each quarter-wave sine sums at most TERMS_MAX series terms;
//   vertex and cfg ready stay low meanwhile.
// Reset (synchronous, active low): operation move x, offset 0, sin 0, cos 1.0.

module vertex_translate_rotate #(
    parameter int COORD_WIDTH = vtr_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = vtr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [vtr_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]                 i_cfg_data,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic signed [COORD_WIDTH-1:0]          i_coord_x,
    input  wire logic signed [COORD_WIDTH-1:0]          i_coord_y,
    input  wire logic signed [COORD_WIDTH-1:0]          i_coord_z,
    input  wire logic                                   i_vertex_last,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic signed [COORD_WIDTH-1:0]               o_out_x,
    output logic signed [COORD_WIDTH-1:0]               o_out_y,
    output logic signed [COORD_WIDTH-1:0]               o_out_z,
    output logic                                        o_out_last
);

    vtr_pkg::t_op                   r_operation;
    logic signed [COORD_WIDTH-1:0]  r_offset;

    logic                           cfg_write;
    logic                           angle_write;
    logic                           coef_busy;
    logic signed [FRAC_BITS+1:0]    coef_sin;
    logic signed [FRAC_BITS+1:0]    coef_cos;
    logic                           xf_ready;

    assign o_cfg_ready = !coef_busy;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign angle_write = cfg_write && (i_cfg_index == vtr_pkg::CFG_ANGLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= vtr_pkg::OP_MOVE_X;
            r_offset    <= '0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                vtr_pkg::CFG_OPERATION: r_operation <= vtr_pkg::t_op'(i_cfg_data[2:0]);
                vtr_pkg::CFG_OFFSET:    r_offset    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vtr_coef #(
        .FRAC_BITS (FRAC_BITS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (angle_write),
        .i_angle (i_cfg_data[vtr_pkg::ANGLE_WIDTH-1:0]),
        .o_busy  (coef_busy),
        .o_sin   (coef_sin),
        .o_cos   (coef_cos)
    );

    vtr_xform #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_xform (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid && !coef_busy),
        .o_ready       (xf_ready),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_vertex_last (i_vertex_last),
        .i_operation   (r_operation),
        .i_offset      (r_offset),
        .i_sin         (coef_sin),
        .i_cos         (coef_cos),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_out_last    (o_out_last)
    );

    assign o_ready = xf_ready && !coef_busy;

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        coef_busy |-> !o_ready && !o_cfg_ready)
        else $error("word taken during coefficient update");

endmodule

`default_nettype wire

// ----- rtl/core/vtr_coef.sv -----
`default_nettype none

module vtr_coef #(
    parameter int FRAC_BITS = vtr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_start,
    input  wire logic signed [vtr_pkg::ANGLE_WIDTH-1:0]   i_angle,
    output logic                                          o_busy,
    output logic signed [FRAC_BITS+1:0]                   o_sin,
    output logic signed [FRAC_BITS+1:0]                   o_cos
);

    localparam int CF  = FRAC_BITS + 2;
    localparam int QW  = vtr_pkg::Q_WIDTH;
    localparam int HW  = QW / 2;
    localparam int DW  = vtr_pkg::DIV_WIDTH;
    localparam int TW  = vtr_pkg::TURN_WIDTH;
    localparam int NW  = vtr_pkg::QSINE_WIDTH;
    localparam int KW  = $clog2(vtr_pkg::TERMS_MAX + 1);
    localparam int CW  = 6;
    localparam int RW  = DW + NW;
    localparam int MW  = RW + 1;
    localparam int RS  = RW + DW;

    localparam logic [QW-1:0] PI_BASE = vtr_pkg::PI_Q60 / QW'(vtr_pkg::HALF_TURN);
    localparam logic [DW-1:0] PI_REM  = DW'(vtr_pkg::PI_Q60 % QW'(vtr_pkg::HALF_TURN));
    localparam logic [MW-1:0] PI_RECIP =
        MW'(((QW'(1) << RS) + QW'(vtr_pkg::HALF_TURN - 1)) / QW'(vtr_pkg::HALF_TURN));
    localparam logic [QW-1:0] ROUND_BIAS = QW'(1) << (vtr_pkg::Q_FRAC - 1 - FRAC_BITS);
    localparam logic signed [CF-1:0] COEF_ONE = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic [CW-1:0] MUL_LAST = CW'(4);
    localparam logic [CW-1:0] DIV_LAST = CW'(QW - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_DIV_X,
        S_MUL_X2,
        S_CHECK,
        S_MUL_T,
        S_DIV_T,
        S_ROUND
    } t_state;

    t_state                 r_state;
    logic signed [CF-1:0]   r_sin;
    logic signed [CF-1:0]   r_cos;
    logic [1:0]             r_quad;
    logic [NW-1:0]          r_r;
    logic [NW-1:0]          r_n;
    logic                   r_pass;
    logic [FRAC_BITS:0]     r_sr;
    logic [QW-1:0]          r_xbase;
    logic [QW-1:0]          r_x2;
    logic [QW-1:0]          r_term;
    logic [QW-1:0]          r_sum;
    logic [KW-1:0]          r_k;
    logic [CW-1:0]          r_cnt;
    logic [QW-1:0]          r_ma;
    logic [QW-1:0]          r_mb;
    logic [QW-1:0]          r_pp;
    logic [1:0]             r_pp_sh;
    logic                   r_pp_v;
    logic [2*QW-1:0]        r_acc;
    logic [QW-1:0]          r_dq;
    logic [DW-1:0]          r_dr;
    logic [DW-1:0]          r_dd;

    logic [TW-1:0]          n_a0;
    logic [TW-1:0]          n_a1;
    logic [TW-1:0]          n_a2;
    logic [TW-1:0]          n_a3;
    logic [1:0]             n_quad;
    logic [NW-1:0]          n_rem;
    logic [HW-1:0]          n_a_half;
    logic [HW-1:0]          n_b_half;
    logic [QW-1:0]          n_pp;
    logic [1:0]             n_pp_sh;
    logic [2*QW-1:0]        n_acc;
    logic [QW-1:0]          n_mres;
    logic [DW:0]            n_rem_sh;
    logic                   n_ge;
    logic [DW-1:0]          n_dr;
    logic [QW-1:0]          n_dq;
    logic [RW+MW-1:0]       n_recip_p;
    logic [QW-1:0]          n_x;
    logic [DW-1:0]          n_kk;
    logic [DW-1:0]          n_div_k;
    logic [QW-1:0]          n_sum_rnd;
    logic [FRAC_BITS:0]     n_round;
    logic signed [CF-1:0]   n_sr;
    logic signed [CF-1:0]   n_sc;

    // angle folded into one turn, then split into quadrant and remainder
    always_comb begin
        n_a0 = TW'((TW+1)'(i_angle) + (TW+1)'(2 * vtr_pkg::FULL_TURN));
        n_a1 = (n_a0 >= TW'(vtr_pkg::FULL_TURN)) ? n_a0 - TW'(vtr_pkg::FULL_TURN) : n_a0;
        n_a2 = (n_a1 >= TW'(vtr_pkg::FULL_TURN)) ? n_a1 - TW'(vtr_pkg::FULL_TURN) : n_a1;
        n_a3 = (n_a2 >= TW'(vtr_pkg::FULL_TURN)) ? n_a2 - TW'(vtr_pkg::FULL_TURN) : n_a2;
        if (n_a3 < TW'(vtr_pkg::QUARTER_TURN)) begin
            n_quad = 2'd0;
            n_rem  = NW'(n_a3);
        end else if (n_a3 < TW'(vtr_pkg::HALF_TURN)) begin
            n_quad = 2'd1;
            n_rem  = NW'(n_a3 - TW'(vtr_pkg::QUARTER_TURN));
        end else if (n_a3 < TW'(vtr_pkg::HALF_TURN + vtr_pkg::QUARTER_TURN)) begin
            n_quad = 2'd2;
            n_rem  = NW'(n_a3 - TW'(vtr_pkg::HALF_TURN));
        end else begin
            n_quad = 2'd3;
            n_rem  = NW'(n_a3 - TW'(vtr_pkg::HALF_TURN + vtr_pkg::QUARTER_TURN));
        end
    end

    // shared 32x32 partial product multiplier and radix-2 divider
    always_comb begin
        n_a_half  = r_cnt[1] ? r_ma[QW-1:HW] : r_ma[HW-1:0];
        n_b_half  = r_cnt[0] ? r_mb[QW-1:HW] : r_mb[HW-1:0];
        n_pp      = n_a_half * n_b_half;
        n_pp_sh   = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
        n_acc     = r_acc + (r_pp_v ? ({{QW{1'b0}}, r_pp} << {r_pp_sh, 5'b0}) : '0);
        n_mres    = n_acc[vtr_pkg::Q_FRAC +: QW];

        n_rem_sh  = {r_dr, r_dq[QW-1]};
        n_ge      = (n_rem_sh >= {1'b0, r_dd});
        n_dr      = DW'(n_ge ? n_rem_sh - {1'b0, r_dd} : n_rem_sh);
        n_dq      = {r_dq[QW-2:0], n_ge};

        // pi remainder share over a half turn, by reciprocal multiply
        n_recip_p = r_dq[RW-1:0] * PI_RECIP;
        n_x       = r_xbase + QW'(n_recip_p[RW+MW-1:RS]);

        n_kk      = DW'({r_k, 1'b0});
        n_div_k   = n_kk * (n_kk + DW'(1));

        n_sum_rnd = r_sum + ROUND_BIAS;
        n_round   = n_sum_rnd[vtr_pkg::Q_FRAC -: FRAC_BITS+1];
        n_sr      = {1'b0, r_sr};
        n_sc      = {1'b0, n_round};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sin   <= '0;
            r_cos   <= COEF_ONE;
        end else begin
            unique case (r_state) inside
                S_IDLE: begin
                    if (i_start) begin
                        r_quad  <= n_quad;
                        r_r     <= n_rem;
                        r_n     <= n_rem;
                        r_pass  <= 1'b0;
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    r_xbase <= QW'(PI_BASE * QW'(r_n));
                    r_dq    <= QW'(PI_REM * QW'(r_n));
                    r_state <= S_DIV_X;
                end
                S_DIV_X: begin
                    r_term  <= n_x;
                    r_sum   <= n_x;
                    r_k     <= KW'(1);
                    r_ma    <= n_x;
                    r_mb    <= n_x;
                    r_acc   <= '0;
                    r_pp_v  <= 1'b0;
                    r_cnt   <= '0;
                    r_state <= S_MUL_X2;
                end
                S_DIV_T: begin
                    r_dq  <= n_dq;
                    r_dr  <= n_dr;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == DIV_LAST) begin
                        r_term  <= n_dq;
                        r_sum   <= r_k[0] ? r_sum - n_dq : r_sum + n_dq;
                        r_k     <= r_k + KW'(1);
                        r_state <= S_CHECK;
                    end
                end
                S_MUL_X2, S_MUL_T: begin
                    r_pp    <= n_pp;
                    r_pp_sh <= n_pp_sh;
                    r_pp_v  <= (r_cnt < MUL_LAST);
                    r_acc   <= n_acc;
                    if (r_cnt == MUL_LAST) begin
                        r_cnt <= '0;
                        if (r_state == S_MUL_X2) begin
                            r_x2    <= n_mres;
                            r_state <= S_CHECK;
                        end else begin
                            r_dq    <= n_mres;
                            r_dd    <= n_div_k;
                            r_dr    <= '0;
                            r_state <= S_DIV_T;
                        end
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_CHECK: begin
                    if (r_k < KW'(vtr_pkg::TERMS_MAX) && r_term != '0) begin
                        r_ma    <= r_term;
                        r_mb    <= r_x2;
                        r_acc   <= '0;
                        r_pp_v  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_MUL_T;
                    end else begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (!r_pass) begin
                        r_sr    <= n_round;
                        r_pass  <= 1'b1;
                        r_n     <= NW'(vtr_pkg::QUARTER_TURN) - r_r;
                        r_state <= S_SEED;
                    end else begin
                        case (r_quad)
                            2'd0: begin
                                r_sin <= n_sr;
                                r_cos <= n_sc;
                            end
                            2'd1: begin
                                r_sin <= n_sc;
                                r_cos <= -n_sr;
                            end
                            2'd2: begin
                                r_sin <= -n_sr;
                                r_cos <= -n_sc;
                            end
                            default: begin
                                r_sin <= -n_sc;
                                r_cos <= n_sr;
                            end
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("coefficient update did not start");

    a_coef_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy && $past(!o_busy) && $past(i_rst_n) |-> $stable(o_sin) && $stable(o_cos))
        else $error("coefficients changed while idle");

    a_coef_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_sin == '0 && o_cos == '0))
        else $error("sine and cosine both zero");

endmodule

`default_nettype wire

// ----- rtl/core/vtr_xform.sv -----
`default_nettype none

module vtr_xform #(
    parameter int COORD_WIDTH = vtr_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = vtr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [COORD_WIDTH-1:0]  i_coord_x,
    input  wire logic signed [COORD_WIDTH-1:0]  i_coord_y,
    input  wire logic signed [COORD_WIDTH-1:0]  i_coord_z,
    input  wire logic                           i_vertex_last,
    input  wire vtr_pkg::t_op                   i_operation,
    input  wire logic signed [COORD_WIDTH-1:0]  i_offset,
    input  wire logic signed [FRAC_BITS+1:0]    i_sin,
    input  wire logic signed [FRAC_BITS+1:0]    i_cos,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [COORD_WIDTH-1:0]       o_out_x,
    output logic signed [COORD_WIDTH-1:0]       o_out_y,
    output logic signed [COORD_WIDTH-1:0]       o_out_z,
    output logic                                o_out_last
);

    localparam int CW = COORD_WIDTH;
    localparam int CF = FRAC_BITS + 2;
    localparam int PW = CW + CF + 2;

    localparam logic signed [PW-1:0] SAT_HI = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = {{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [PW-1:0] RND    = PW'(1) << (FRAC_BITS - 1);

    logic                   r_s1_valid;
    logic signed [CW-1:0]   r_s1_x;
    logic signed [CW-1:0]   r_s1_y;
    logic signed [CW-1:0]   r_s1_z;
    logic                   r_s1_last;
    logic                   r_s2_valid;
    logic signed [CW-1:0]   r_s2_x;
    logic signed [CW-1:0]   r_s2_y;
    logic signed [CW-1:0]   r_s2_z;
    logic                   r_s2_last;

    logic                   s1_ready;
    logic                   s2_ready;

    logic signed [CW-1:0]   n_a;
    logic signed [CW-1:0]   n_b;
    logic signed [CF-1:0]   n_s;
    logic signed [CW+CF-1:0] n_ca;
    logic signed [CW+CF-1:0] n_sb;
    logic signed [CW+CF-1:0] n_sa;
    logic signed [CW+CF-1:0] n_cb;
    logic signed [PW-1:0]   n_u_sum;
    logic signed [PW-1:0]   n_v_sum;
    logic signed [CW-1:0]   n_u;
    logic signed [CW-1:0]   n_v;
    logic signed [CW-1:0]   n_msel;
    logic signed [CW:0]     n_move_sum;
    logic signed [CW-1:0]   n_move;
    logic signed [CW-1:0]   n_x;
    logic signed [CW-1:0]   n_y;
    logic signed [CW-1:0]   n_z;

    function automatic logic signed [CW-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [CW-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[CW-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[CW-1:0];
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    assign s2_ready = !r_s2_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    // u = c*a - s*b, v = s*a + c*b; rotation about y flips the sign of s
    always_comb begin
        n_s = (i_operation == vtr_pkg::OP_ROT_Y) ? -i_sin : i_sin;
        case (i_operation)
            vtr_pkg::OP_ROT_X: begin
                n_a = r_s1_y;
                n_b = r_s1_z;
            end
            vtr_pkg::OP_ROT_Y: begin
                n_a = r_s1_x;
                n_b = r_s1_z;
            end
            default: begin
                n_a = r_s1_x;
                n_b = r_s1_y;
            end
        endcase
        n_ca    = n_a * i_cos;
        n_sb    = n_b * n_s;
        n_sa    = n_a * n_s;
        n_cb    = n_b * i_cos;
        n_u_sum = PW'(n_ca) - PW'(n_sb) + RND;
        n_v_sum = PW'(n_sa) + PW'(n_cb) + RND;
        n_u     = sat(n_u_sum >>> FRAC_BITS);
        n_v     = sat(n_v_sum >>> FRAC_BITS);

        case (i_operation)
            vtr_pkg::OP_MOVE_Y: n_msel = r_s1_y;
            vtr_pkg::OP_MOVE_Z: n_msel = r_s1_z;
            default:            n_msel = r_s1_x;
        endcase
        n_move_sum = (CW+1)'(n_msel) + (CW+1)'(i_offset);
        n_move     = sat(PW'(n_move_sum));

        n_x = r_s1_x;
        n_y = r_s1_y;
        n_z = r_s1_z;
        unique case (i_operation)
            vtr_pkg::OP_MOVE_X: begin
                n_x = n_move;
            end
            vtr_pkg::OP_MOVE_Y: begin
                n_y = n_move;
            end
            vtr_pkg::OP_MOVE_Z: begin
                n_z = n_move;
            end
            vtr_pkg::OP_ROT_X: begin
                n_y = n_u;
                n_z = n_v;
            end
            vtr_pkg::OP_ROT_Y: begin
                n_x = n_u;
                n_z = n_v;
            end
            vtr_pkg::OP_ROT_Z: begin
                n_x = n_u;
                n_y = n_v;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_ready) begin
            r_s1_x    <= i_coord_x;
            r_s1_y    <= i_coord_y;
            r_s1_z    <= i_coord_z;
            r_s1_last <= i_vertex_last;
        end
        if (r_s1_valid && s2_ready) begin
            r_s2_x    <= n_x;
            r_s2_y    <= n_y;
            r_s2_z    <= n_z;
            r_s2_last <= r_s1_last;
        end
    end

    assign o_ready    = s1_ready;
    assign o_valid    = r_s2_valid;
    assign o_out_x    = r_s2_x;
    assign o_out_y    = r_s2_y;
    assign o_out_z    = r_s2_z;
    assign o_out_last = r_s2_last;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_ready |=> r_s1_valid && $stable(r_s1_x) && $stable(r_s1_last))
        else $error("input stage lost a word while blocked");

    a_s2_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s1_valid))
        else $error("result word without a word in the input stage");

endmodule

`default_nettype wire

// ----- bench/vertex_check_pkg.sv -----
package vertex_check_pkg;

    import vtr_pkg::*;

    localparam int CW   = COORD_WIDTH_DEF;
    localparam int FRAC = FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 last;
    } vertex_t;

    function automatic vertex_t mk_vertex(logic [CW-1:0] x, logic [CW-1:0] y,
                                          logic [CW-1:0] z, logic last);
        vertex_t v;
        v.x    = x;
        v.y    = y;
        v.z    = z;
        v.last = last;
        return v;
    endfunction

    class vertex_scoreboard;
        vertex_t     expected_q[$];
        logic [2:0]  operation;
        longint      move_offset;
        longint      cos_coef;
        longint      sin_coef;
        int          mismatches;

        function void reset_state();
            operation   = OP_MOVE_X;
            move_offset = 0;
            cos_coef    = longint'(1) << FRAC;
            sin_coef    = 0;
            mismatches  = 0;
            expected_q.delete();
        endfunction

        // (a * b) >> 60, unsigned Q60
        function logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[123:60];
        endfunction

        // sine of n sixteenths of a degree, n in 0..QUARTER_TURN, scaled by 2^FRAC
        function longint quarter_wave(int n);
            logic [63:0] nn;
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] sum;
            int          k;
            nn   = 64'(n);
            x    = (PI_Q60 / 64'(HALF_TURN)) * nn
                 + ((PI_Q60 % 64'(HALF_TURN)) * nn) / 64'(HALF_TURN);
            x2   = mul_q60(x, x);
            term = x;
            sum  = x;
            for (k = 1; k < TERMS_MAX && term != 0; k++) begin
                term = mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            sum = (sum + (64'd1 << (Q_FRAC - 1 - FRAC))) >> (Q_FRAC - FRAC);
            return longint'(sum);
        endfunction

        function void load_angle(logic signed [ANGLE_WIDTH-1:0] ang);
            int     a;
            int     quad;
            int     rem;
            longint sr;
            longint sc;
            a    = (int'(ang) + 2 * FULL_TURN) % FULL_TURN;
            quad = a / QUARTER_TURN;
            rem  = a % QUARTER_TURN;
            sr   = quarter_wave(rem);
            sc   = quarter_wave(QUARTER_TURN - rem);
            case (quad)
                0: begin sin_coef = sr;  cos_coef = sc;  end
                1: begin sin_coef = sc;  cos_coef = -sr; end
                2: begin sin_coef = -sr; cos_coef = -sc; end
                default: begin sin_coef = -sc; cos_coef = sr; end
            endcase
        endfunction

        function void set_register(logic [CFG_INDEX_WIDTH-1:0] index, logic [CW-1:0] data);
            case (index)
                CFG_OPERATION: operation = data[2:0];
                CFG_OFFSET:    move_offset = longint'(signed'(data));
                CFG_ANGLE:     load_angle(data[ANGLE_WIDTH-1:0]);
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) << (CW - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // round half up of (c*p + d*q) / 2^FRAC, saturated
        function longint rotate_term(longint c, longint p, longint d, longint q);
            longint v;
            v = c * p + d * q + (longint'(1) << (FRAC - 1));
            return clamp(v >>> FRAC);
        endfunction

        function void note_vertex(vertex_t v);
            longint  x;
            longint  y;
            longint  z;
            longint  nx;
            longint  ny;
            longint  nz;
            vertex_t r;
            x  = longint'(v.x);
            y  = longint'(v.y);
            z  = longint'(v.z);
            nx = x;
            ny = y;
            nz = z;
            case (operation)
                OP_MOVE_X: nx = clamp(x + move_offset);
                OP_MOVE_Y: ny = clamp(y + move_offset);
                OP_MOVE_Z: nz = clamp(z + move_offset);
                OP_ROT_X: begin
                    ny = rotate_term(cos_coef, y, -sin_coef, z);
                    nz = rotate_term(sin_coef, y, cos_coef, z);
                end
                OP_ROT_Y: begin
                    nx = rotate_term(cos_coef, x, sin_coef, z);
                    nz = rotate_term(-sin_coef, x, cos_coef, z);
                end
                OP_ROT_Z: begin
                    nx = rotate_term(cos_coef, x, -sin_coef, y);
                    ny = rotate_term(sin_coef, x, cos_coef, y);
                end
                default: ;
            endcase
            r = mk_vertex(nx[CW-1:0], ny[CW-1:0], nz[CW-1:0], v.last);
            expected_q.push_back(r);
        endfunction

        function void check_vertex(vertex_t got);
            vertex_t exp_v;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: %h %h %h last %b",
                             got.x, got.y, got.z, got.last);
                end
                return;
            end
            exp_v = expected_q.pop_front();
            if (got.x !== exp_v.x || got.y !== exp_v.y || got.z !== exp_v.z ||
                got.last !== exp_v.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result word mismatch: expected %h %h %h last %b, got %h %h %h last %b",
                             exp_v.x, exp_v.y, exp_v.z, exp_v.last,
                             got.x, got.y, got.z, got.last);
                end
            end
        endfunction
    endclass

endpackage

// ----- bench/tb.sv -----
module tb;

    import vtr_pkg::*;
    import vertex_check_pkg::*;

    localparam logic [2:0]                 OP_SPARE_6 = 3'd6;
    localparam logic [2:0]                 OP_SPARE_7 = 3'd7;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE  = 2'd3;
    localparam logic [CW-1:0]              COORD_MAX  = 32'h7fffffff;
    localparam logic [CW-1:0]              COORD_MIN  = 32'h80000000;
    localparam int                         CYCLE_LIMIT = 1000000;
    localparam int                         HOLD_CYCLES = 300;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CW-1:0]              cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [CW-1:0]       coord_x = '0;
    logic signed [CW-1:0]       coord_y = '0;
    logic signed [CW-1:0]       coord_z = '0;
    logic                       vertex_last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [CW-1:0]       out_x;
    logic signed [CW-1:0]       out_y;
    logic signed [CW-1:0]       out_z;
    logic                       out_last;

    int send_idle_pct = 36;
    int recv_idle_pct = 80;
    int holds_asked   = 0;
    int holds_done    = 0;
    int hold_left     = 0;

    vertex_scoreboard sb;

    vertex_translate_rotate u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_coord_x     (coord_x),
        .i_coord_y     (coord_y),
        .i_coord_z     (coord_z),
        .i_vertex_last (vertex_last),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_out_x       (out_x),
        .o_out_y       (out_y),
        .o_out_z       (out_z),
        .o_out_last    (out_last)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        sb = new;
        sb.reset_state();
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                sb.set_register(cfg_index, cfg_data);
            end
            if (in_valid && in_ready) begin
                sb.note_vertex(mk_vertex(coord_x, coord_y, coord_z, vertex_last));
            end
            if (out_valid && out_ready) begin
                sb.check_vertex(mk_vertex(out_x, out_y, out_z, out_last));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_vertex(vertex_t v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        coord_x     <= v.x;
        coord_y     <= v.y;
        coord_z     <= v.z;
        vertex_last <= v.last;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [CW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits beyond each register's width are noise
    task automatic set_op(logic [2:0] op);
        logic [CW-1:0] d;
        d = $urandom;
        d[2:0] = op;
        write_reg(CFG_OPERATION, d);
    endtask

    task automatic set_angle(logic signed [ANGLE_WIDTH-1:0] ang);
        logic [CW-1:0] d;
        d = $urandom;
        d[ANGLE_WIDTH-1:0] = ang;
        write_reg(CFG_ANGLE, d);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        int t;
        case ($urandom_range(4))
            0, 1: return $urandom;
            2: begin
                t = int'($urandom_range(0, 524288)) - 262144;
                return t;
            end
            3: begin
                case ($urandom_range(4))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    3: return '1;
                    default: return 32'd1;
                endcase
            end
            default: begin
                if ($urandom_range(1)) return COORD_MAX - $urandom_range(0, 32'h30000);
                return COORD_MIN + $urandom_range(0, 32'h30000);
            end
        endcase
    endfunction

    function automatic logic signed [ANGLE_WIDTH-1:0] rand_angle();
        int a;
        case ($urandom_range(3))
            0: a = int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
            1: a = int'($urandom_range(0, 16383)) - 8192;
            2: begin
                case ($urandom_range(5))
                    0: a = -8192;
                    1: a = 8191;
                    2: a = -FULL_TURN;
                    3: a = FULL_TURN;
                    4: a = 0;
                    default: a = QUARTER_TURN;
                endcase
            end
            default: a = QUARTER_TURN * int'($urandom_range(0, 4)) - 2 * QUARTER_TURN
                       + int'($urandom_range(0, 6)) - 3;
        endcase
        return a[ANGLE_WIDTH-1:0];
    endfunction

    task automatic random_config();
        logic [2:0]    op;
        logic [CW-1:0] ofs;
        int            t;
        if ($urandom_range(9) == 0) begin
            op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        end else begin
            op = 3'($urandom_range(OP_ROT_Z));
        end
        case ($urandom_range(3))
            0, 1: ofs = $urandom;
            2: begin
                t = int'($urandom_range(0, 32'h100000)) - 32'h80000;
                ofs = t;
            end
            default: ofs = $urandom_range(1) ? COORD_MAX : COORD_MIN;
        endcase
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_SPARE, $urandom);
        end
        set_angle(rand_angle());
        write_reg(CFG_OFFSET, ofs);
        set_op(op);
    endtask

    initial begin
        int mode;
        int ph;
        int n;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: move x by zero
        send_vertex(mk_vertex(COORD_MAX, COORD_MIN, 32'd1, 1'b1));
        send_vertex(mk_vertex(COORD_MIN, COORD_MAX, '1, 1'b0));

        drain();
        write_reg(CFG_OFFSET, COORD_MAX);
        send_vertex(mk_vertex(COORD_MAX, '0, '0, 1'b0));
        send_vertex(mk_vertex(COORD_MIN, '0, '0, 1'b0));
        send_vertex(mk_vertex(32'd1, '0, '0, 1'b1));

        drain();
        write_reg(CFG_OFFSET, COORD_MIN);
        send_vertex(mk_vertex(COORD_MIN, '0, '0, 1'b0));
        send_vertex(mk_vertex(COORD_MAX, '0, '0, 1'b0));
        send_vertex(mk_vertex('1, '0, '0, 1'b0));

        drain();
        set_op(OP_MOVE_Y);
        write_reg(CFG_OFFSET, 32'h00018000);
        send_vertex(mk_vertex('0, COORD_MAX, '0, 1'b0));
        send_vertex(mk_vertex(32'd5, 32'h12345678, 32'd7, 1'b1));

        drain();
        set_op(OP_MOVE_Z);
        write_reg(CFG_OFFSET, COORD_MIN);
        send_vertex(mk_vertex('0, '0, COORD_MIN, 1'b0));
        send_vertex(mk_vertex('0, '0, 32'h00010000, 1'b0));

        // angles beyond a full turn wrap around
        drain();
        set_op(OP_ROT_X);
        set_angle(14'sd8191);
        send_vertex(mk_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        send_vertex(mk_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));

        drain();
        set_op(OP_ROT_Y);
        set_angle(-14'sd8192);
        send_vertex(mk_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        send_vertex(mk_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));

        // 30 degrees: sine is exactly one half, so unit inputs land on ties
        drain();
        set_op(OP_ROT_Z);
        set_angle(14'sd480);
        send_vertex(mk_vertex(32'd1, '0, '0, 1'b0));
        send_vertex(mk_vertex('1, '0, '0, 1'b0));
        send_vertex(mk_vertex(COORD_MAX, COORD_MIN, 32'd3, 1'b1));

        drain();
        set_angle(14'sd1440);
        send_vertex(mk_vertex(COORD_MIN, COORD_MAX, '0, 1'b0));

        // write to a nonexistent register must change nothing
        drain();
        write_reg(CFG_SPARE, $urandom);
        send_vertex(mk_vertex(32'h00020000, 32'h00030000, 32'hfffc0000, 1'b0));

        drain();
        set_op(OP_SPARE_6);
        send_vertex(mk_vertex(COORD_MAX, COORD_MIN, $urandom, 1'b1));
        drain();
        set_op(OP_SPARE_7);
        send_vertex(mk_vertex($urandom, $urandom, $urandom, 1'b0));

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 36; recv_idle_pct = 80; end
                1: begin send_idle_pct = 80; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (ph = 0; ph < 6; ph++) begin
                drain();
                random_config();
                if (mode == 2 && ph == 1) begin
                    holds_asked = holds_asked + 1;
                end
                for (n = 0; n < 50; n++) begin
                    send_vertex(mk_vertex(rand_coord(), rand_coord(), rand_coord(),
                                          1'($urandom_range(1))));
                end
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
